@@ hw/rtl/gsrch_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph search package
// Opcodes, field widths and the result type shared by the graph search block.
// ----------------------------------------------------------------------------
package gsrch_pkg;

    localparam int OP_W    = 3;
    localparam int VTX_W   = 6;
    localparam int EDGE_W  = 10;
    localparam int MAX_RES = 32;
    localparam int CNT_W   = 6;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_BFS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DFS  = 3'd3;
    localparam logic [OP_W-1:0] OP_TEST = 3'd4;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             found;
        logic             present;
        logic             error;
        logic             last;
    } t_res;

endpackage

@@ hw/rtl/gsrch_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph search channels
// Command channel and result channel, each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gsrch_cmd_if import gsrch_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [VTX_W-1:0] node_a;
    logic [VTX_W-1:0] node_b;

    modport source (output valid, output opcode, output node_a, output node_b, input ready);
    modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

interface gsrch_res_if import gsrch_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VTX_W-1:0]  visited_vertex;
    logic              found;
    logic              edge_present;
    logic              error;
    logic [EDGE_W-1:0] edge_total;
    logic              last;

    modport source (output valid, output visited_vertex, output found, output edge_present,
                    output error, output edge_total, output last, input ready);
    modport sink   (input valid, input visited_vertex, input found, input edge_present,
                    input error, input edge_total, input last, output ready);
endinterface

@@ hw/rtl/gsrch_adj_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency row memory
// One row per vertex, one write and one registered read per cycle. Row valid
// bits make every row read as zero after reset until it is first written.
// ----------------------------------------------------------------------------
module gsrch_adj_mem #(
    parameter int VERTICES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(VERTICES)-1:0] i_rd_addr,
    output logic [VERTICES-1:0]         o_rd_row,
    input  logic                        i_wr_en,
    input  logic [$clog2(VERTICES)-1:0] i_wr_addr,
    input  logic [VERTICES-1:0]         i_wr_row
);

    logic [VERTICES-1:0] r_mem [VERTICES];
    logic [VERTICES-1:0] r_row_valid;
    logic [VERTICES-1:0] r_rd_row;
    logic                r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_wr_en) begin
            r_row_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
            r_rd_ok  <= r_row_valid[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_ok ? r_rd_row : '0;

endmodule

@@ hw/rtl/gsrch_work_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work store
// Queue or stack entries of a search, one write and one registered read per
// cycle. Entries are always written before they are read.
// ----------------------------------------------------------------------------
module gsrch_work_mem import gsrch_pkg::*; #(
    parameter int VERTICES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(VERTICES)-1:0] i_rd_addr,
    output logic [VTX_W-1:0]            o_rd_data,
    input  logic                        i_wr_en,
    input  logic [$clog2(VERTICES)-1:0] i_wr_addr,
    input  logic [VTX_W-1:0]            i_wr_data
);

    logic [VTX_W-1:0] r_mem [VERTICES];
    logic [VTX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/gsrch_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor scan unit
// Holds the unvisited neighbors of the current vertex and hands out one per
// cycle while i_step is high, lowest first or highest first.
// ----------------------------------------------------------------------------
module gsrch_scan #(
    parameter int VERTICES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [VERTICES-1:0]         i_load_row,
    input  logic                        i_step,
    input  logic                        i_lowest,
    output logic                        o_empty,
    output logic [$clog2(VERTICES)-1:0] o_pick
);

    localparam int AW = $clog2(VERTICES);

    logic [VERTICES-1:0] r_scan;
    logic [AW-1:0]       w_pick;
    logic                w_hit;

    // Ascending sweep: the first hit wins when picking lowest, the last otherwise.
    always_comb begin
        w_pick = '0;
        w_hit  = 1'b0;
        for (int i = 0; i < VERTICES; i++) begin
            if (r_scan[i] && (!i_lowest || !w_hit)) begin
                w_pick = AW'(i);
                w_hit  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_load) begin
            r_scan <= i_load_row;
        end else if (i_step) begin
            r_scan[w_pick] <= 1'b0;
        end
    end

    assign o_empty = !w_hit;
    assign o_pick  = w_pick;

endmodule

@@ hw/rtl/adjacency_matrix_graph_search.sv @@
`timescale 1ns / 1ps
// An edge add or remove that changes the graph goes through ST_RDA, ST_RDB, ST_WRB and ST_EMIT
// from accept to result, any other edge operation skips ST_WRB, and a rejected item goes straight
// to ST_EMIT. A search runs ST_POP, ST_VTX, ST_ROW and ST_SCAN per popped vertex, a further ST_SCAN
// step for each neighbor it queues, and ST_EMIT to hand over each result item; the single matrix read
// port and the scan unit set this order. One item is in work at a time; ready is high only while idle.
// Reset clears the edge count and the row valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// Adjacency matrix graph search
// Undirected graph kept as a bit matrix with edge add, remove and test, and a
// breadth-first or depth-first search that emits every popped vertex.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_search import gsrch_pkg::*; #(
    parameter int VERTICES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gsrch_cmd_if.sink         i_cmd,
    gsrch_res_if.source       o_res
);

    localparam int AW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES + 1);
    localparam logic [VTX_W:0]   MAX_V   = (VTX_W + 1)'(VERTICES);
    localparam logic [CW-1:0]    V_CNT   = CW'(VERTICES);
    localparam logic [CNT_W-1:0] RES_CNT = CNT_W'(MAX_RES);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDA  = 4'd1;
    localparam logic [3:0] ST_RDB  = 4'd2;
    localparam logic [3:0] ST_WRB  = 4'd3;
    localparam logic [3:0] ST_POP  = 4'd4;
    localparam logic [3:0] ST_VTX  = 4'd5;
    localparam logic [3:0] ST_ROW  = 4'd6;
    localparam logic [3:0] ST_SCAN = 4'd7;
    localparam logic [3:0] ST_EMIT = 4'd8;

    logic [3:0]        r_state;
    logic [OP_W-1:0]   r_op;
    logic [VTX_W-1:0]  r_a;
    logic [VTX_W-1:0]  r_b;
    logic [EDGE_W-1:0] r_edge_cnt;
    logic [VERTICES-1:0] r_row_a;
    logic [VERTICES-1:0] r_row_b;
    logic [VERTICES-1:0] r_visited;
    logic [CW-1:0]     r_head;
    logic [CW-1:0]     r_tail;
    logic [CNT_W-1:0]  r_cnt;
    logic [VTX_W-1:0]  r_v;
    t_res              r_res;
    t_res              r_out;
    logic [EDGE_W-1:0] r_out_total;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_lowest;
    logic              w_a_ok;
    logic              w_b_ok;
    logic [AW-1:0]     w_a_idx;
    logic [AW-1:0]     w_b_idx;
    logic [AW-1:0]     w_v_idx;
    logic [CW-1:0]     w_tail_dec;
    logic [CNT_W-1:0]  w_cnt_next;
    logic              w_present;
    logic [VERTICES-1:0] w_bit_a;
    logic [VERTICES-1:0] w_bit_b;

    logic                w_adj_rd_en;
    logic [AW-1:0]       w_adj_rd_addr;
    logic [VERTICES-1:0] w_adj_row;
    logic                w_adj_wr_en;
    logic [AW-1:0]       w_adj_wr_addr;
    logic [VERTICES-1:0] w_adj_wr_row;

    logic                w_wk_rd_en;
    logic [AW-1:0]       w_wk_rd_addr;
    logic [VTX_W-1:0]    w_wk_data;
    logic                w_wk_wr_en;
    logic [AW-1:0]       w_wk_wr_addr;
    logic [VTX_W-1:0]    w_wk_wr_data;

    logic                w_scan_load;
    logic                w_scan_step;
    logic                w_scan_empty;
    logic [AW-1:0]       w_pick;
    logic [VTX_W-1:0]    w_pick_vtx;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_lowest   = (r_op == OP_BFS);

    assign w_a_ok  = (i_cmd.node_a != '0) && ({1'b0, i_cmd.node_a} <= MAX_V);
    assign w_b_ok  = (i_cmd.node_b != '0) && ({1'b0, i_cmd.node_b} <= MAX_V);
    assign w_a_idx = AW'(r_a - VTX_W'(1));
    assign w_b_idx = AW'(r_b - VTX_W'(1));
    assign w_v_idx = AW'(w_wk_data - VTX_W'(1));
    assign w_bit_a = VERTICES'(1) << w_a_idx;
    assign w_bit_b = VERTICES'(1) << w_b_idx;

    assign w_present  = r_row_a[w_b_idx];
    assign w_tail_dec = r_tail - CW'(1);
    assign w_cnt_next = r_cnt + CNT_W'(1);
    assign w_pick_vtx = VTX_W'(w_pick) + VTX_W'(1);

    // Memory port steering; each state uses at most one read and one write per memory.
    always_comb begin
        w_adj_rd_en   = 1'b0;
        w_adj_rd_addr = w_a_idx;
        w_adj_wr_en   = 1'b0;
        w_adj_wr_addr = w_a_idx;
        w_adj_wr_row  = r_row_b;
        w_wk_rd_en    = 1'b0;
        w_wk_rd_addr  = r_head[AW-1:0];
        w_wk_wr_en    = 1'b0;
        w_wk_wr_addr  = r_tail[AW-1:0];
        w_wk_wr_data  = w_pick_vtx;
        w_scan_load   = 1'b0;
        w_scan_step   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_adj_rd_addr = AW'(i_cmd.node_a - VTX_W'(1));
                w_wk_wr_addr  = '0;
                w_wk_wr_data  = i_cmd.node_a;
                if (w_accept && w_a_ok && w_b_ok) begin
                    if (i_cmd.opcode == OP_BFS || i_cmd.opcode == OP_DFS) begin
                        w_wk_wr_en = 1'b1;
                    end else if (i_cmd.opcode <= OP_TEST) begin
                        w_adj_rd_en = 1'b1;
                    end
                end
            end
            ST_RDA: begin
                w_adj_rd_en   = 1'b1;
                w_adj_rd_addr = w_b_idx;
            end
            ST_RDB: begin
                w_adj_wr_addr = w_a_idx;
                if (r_op == OP_ADD && !w_present) begin
                    w_adj_wr_en  = 1'b1;
                    w_adj_wr_row = r_row_a | w_bit_b;
                end else if (r_op == OP_DEL && w_present) begin
                    w_adj_wr_en  = 1'b1;
                    w_adj_wr_row = r_row_a & ~w_bit_b;
                end
            end
            ST_WRB: begin
                w_adj_wr_en   = 1'b1;
                w_adj_wr_addr = w_b_idx;
            end
            ST_POP: begin
                w_wk_rd_en   = 1'b1;
                w_wk_rd_addr = w_lowest ? r_head[AW-1:0] : w_tail_dec[AW-1:0];
            end
            ST_VTX: begin
                w_adj_rd_addr = w_v_idx;
                w_adj_rd_en   = (w_wk_data != r_b) && (w_cnt_next != RES_CNT);
            end
            ST_ROW: begin
                w_scan_load = 1'b1;
            end
            ST_SCAN: begin
                if (!w_scan_empty) begin
                    w_scan_step = 1'b1;
                    w_wk_wr_en  = (r_tail < V_CNT);
                end
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_edge_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_visited   <= '0;
        end else begin
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op  <= i_cmd.opcode;
                        r_a   <= i_cmd.node_a;
                        r_b   <= i_cmd.node_b;
                        r_res <= '{vertex: '0, found: 1'b0, present: 1'b0,
                                   error: (i_cmd.opcode <= OP_TEST) && !(w_a_ok && w_b_ok),
                                   last: 1'b1};
                        if (i_cmd.opcode > OP_TEST) begin
                            r_state <= ST_EMIT;
                        end else if (!w_a_ok || !w_b_ok) begin
                            r_state <= ST_EMIT;
                        end else if (i_cmd.opcode == OP_BFS || i_cmd.opcode == OP_DFS) begin
                            r_visited <= VERTICES'(1) << AW'(i_cmd.node_a - VTX_W'(1));
                            r_head    <= '0;
                            r_tail    <= CW'(1);
                            r_cnt     <= '0;
                            r_state   <= ST_POP;
                        end else begin
                            r_state <= ST_RDA;
                        end
                    end
                end
                ST_RDA: begin
                    r_row_a <= w_adj_row;
                    r_state <= ST_RDB;
                end
                ST_RDB: begin
                    r_res.present <= (r_op == OP_TEST) && w_present;
                    if (r_op == OP_ADD && !w_present) begin
                        r_row_b    <= w_adj_row | w_bit_a;
                        r_edge_cnt <= r_edge_cnt + EDGE_W'(1);
                        r_state    <= ST_WRB;
                    end else if (r_op == OP_DEL && w_present) begin
                        r_row_b    <= w_adj_row & ~w_bit_a;
                        r_edge_cnt <= r_edge_cnt - EDGE_W'(1);
                        r_state    <= ST_WRB;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_WRB: begin
                    r_state <= ST_EMIT;
                end
                ST_POP: begin
                    if (w_lowest) begin
                        r_head <= r_head + CW'(1);
                    end else begin
                        r_tail <= w_tail_dec;
                    end
                    r_state <= ST_VTX;
                end
                ST_VTX: begin
                    r_cnt <= w_cnt_next;
                    r_v   <= w_wk_data;
                    if (w_wk_data == r_b) begin
                        r_res   <= '{vertex: w_wk_data, found: 1'b1, present: 1'b0,
                                     error: 1'b0, last: 1'b1};
                        r_state <= ST_EMIT;
                    end else if (w_cnt_next == RES_CNT) begin
                        r_res   <= '{vertex: w_wk_data, found: 1'b0, present: 1'b0,
                                     error: 1'b0, last: 1'b1};
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_ROW;
                    end
                end
                ST_ROW: begin
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (w_scan_empty) begin
                        // The item ends here when nothing is left to pop.
                        r_res   <= '{vertex: r_v, found: 1'b0, present: 1'b0, error: 1'b0,
                                     last: w_lowest ? (r_head >= r_tail) : (r_tail == '0)};
                        r_state <= ST_EMIT;
                    end else begin
                        r_visited[w_pick] <= 1'b1;
                        if (r_tail < V_CNT) begin
                            r_tail <= r_tail + CW'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_state <= r_res.last ? ST_IDLE : ST_POP;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out       <= r_res;
            r_out_total <= r_edge_cnt;
        end
    end

    gsrch_adj_mem #(.VERTICES(VERTICES)) u_adj_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_adj_rd_en),
        .i_rd_addr (w_adj_rd_addr),
        .o_rd_row  (w_adj_row),
        .i_wr_en   (w_adj_wr_en),
        .i_wr_addr (w_adj_wr_addr),
        .i_wr_row  (w_adj_wr_row)
    );

    gsrch_work_mem #(.VERTICES(VERTICES)) u_work_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_wk_rd_en),
        .i_rd_addr (w_wk_rd_addr),
        .o_rd_data (w_wk_data),
        .i_wr_en   (w_wk_wr_en),
        .i_wr_addr (w_wk_wr_addr),
        .i_wr_data (w_wk_wr_data)
    );

    gsrch_scan #(.VERTICES(VERTICES)) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_scan_load),
        .i_load_row (w_adj_row & ~r_visited),
        .i_step     (w_scan_step),
        .i_lowest   (w_lowest),
        .o_empty    (w_scan_empty),
        .o_pick     (w_pick)
    );

    assign i_cmd.ready          = (r_state == ST_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.visited_vertex = r_out.vertex;
    assign o_res.found          = r_out.found;
    assign o_res.edge_present   = r_out.present;
    assign o_res.error          = r_out.error;
    assign o_res.edge_total     = r_out_total;
    assign o_res.last           = r_out.last;

endmodule

@@ hw/rtl/gsrch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph search port checker
// Watches the ports of the graph search block for rule breaks over time.
// ----------------------------------------------------------------------------
module gsrch_checker import gsrch_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [VTX_W-1:0]  i_vertex,
    input logic              i_found,
    input logic              i_present,
    input logic              i_error,
    input logic [EDGE_W-1:0] i_total,
    input logic              i_last
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_vertex) &&
        $stable(i_found) && $stable(i_present) && $stable(i_error) &&
        $stable(i_total) && $stable(i_last))
        else $error("result item changed while stalled");

    // Every accepted item keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while previous item still in work");

    // A reached target always closes the search.
    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_last && !i_error && (i_vertex != '0))
        else $error("found flag on a non-final result item");

    // Error and edge-test results are single items without a vertex.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_error || i_present) |-> i_last && (i_vertex == '0) && !i_found)
        else $error("error or edge-test result item malformed");

endmodule

bind adjacency_matrix_graph_search gsrch_checker u_gsrch_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_vertex    (o_res.visited_vertex),
    .i_found     (o_res.found),
    .i_present   (o_res.edge_present),
    .i_error     (o_res.error),
    .i_total     (o_res.edge_total),
    .i_last      (o_res.last)
);
